>>> sv/fwht_pkg.sv
`timescale 1ns / 1ps
package fwht_pkg;
  localparam int MaxPoints   = 1024;
  localparam int AddrBits    = $clog2(MaxPoints);
  localparam int ElemBits    = 28;
  localparam int LogMin      = 6;
  localparam int LogMax      = 10;

  localparam logic [1:0] RegLog2Size   = 2'd0;
  localparam logic [1:0] RegScale      = 2'd1;
  localparam logic [1:0] RegUseWeights = 2'd2;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdFlush  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] sample;
    logic signed [15:0] weight;
  } in_item_t;

  typedef struct packed {
    logic signed [27:0] out_value;
    logic [9:0]         out_index;
    logic               out_last;
  } out_item_t;
endpackage

>>> sv/fast_walsh_hadamard_transform.sv
`timescale 1ns / 1ps
// A beat is taken when start is high and busy is low; busy then stays high through
// MUL1, MUL2 and WRITE, so a new beat waits until those end. Its result, if a row
// is pending, strobes out_valid for one cycle; out_valid is registered in MUL1.
// The beat that fills a row also keeps busy high through the row copy (COPY) and
// every butterfly (BFRA, BFRB, BFWA, BFWB on one memory port pair) of each stage.
// rst (synchronous) clears positions, row pending flag and config; no output stall.
module fast_walsh_hadamard_transform (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  fwht_pkg::in_item_t        in_item,
  output logic                      out_valid,
  output fwht_pkg::out_item_t       out_item,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [14:0]               cfg_data
);
  import fwht_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL1  = 9'b000000010,
    S_MUL2  = 9'b000000100,
    S_WRITE = 9'b000001000,
    S_COPY  = 9'b000010000,
    S_BFRA  = 9'b000100000,
    S_BFRB  = 9'b001000000,
    S_BFWA  = 9'b010000000,
    S_BFWB  = 9'b100000000
  } state_t;

  state_t state;
  logic [3:0]  log2_size;
  logic [14:0] scale;
  logic        use_weights;

  logic [ElemBits-1:0] load_mem [MaxPoints];
  logic [ElemBits-1:0] res_mem  [MaxPoints];

  logic [AddrBits-1:0] load_position, drain_position;
  logic                row_ready;
  in_item_t            item;
  logic signed [17:0]  pw;
  logic signed [33:0]  prod;
  logic [ElemBits-1:0] elem;

  // transform sequencer
  logic [AddrBits:0]   cnt;
  logic [3:0]          stage;
  logic [AddrBits-1:0] bf;
  logic [ElemBits-1:0] ld_rd, rs_rd, bf_a, bf_b;

  // clamped size
  logic [3:0]  lg;
  logic [AddrBits:0] n;
  always_comb begin
    lg = log2_size;
    if (lg < 4'(LogMin)) lg = 4'(LogMin);
    if (lg > 4'(LogMax)) lg = 4'(LogMax);
    n = (AddrBits+1)'(1) << lg;
  end

  // butterfly addresses: insert zero at bit `stage`
  logic [AddrBits-1:0] h, lo_mask, addr_a, addr_b;
  always_comb begin
    h       = AddrBits'(1) << stage;
    lo_mask = h - AddrBits'(1);
    addr_a  = ((bf & ~lo_mask) << 1) | (bf & lo_mask);
    addr_b  = addr_a | h;
  end

  assign busy = (state != S_IDLE);

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      log2_size <= 4'd10; scale <= 15'd1024; use_weights <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegLog2Size:   log2_size   <= cfg_data[3:0];
        RegScale:      scale       <= cfg_data;
        RegUseWeights: use_weights <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // memories: load store, and result store with one read and one write port
  logic [AddrBits-1:0] res_ra, res_wa;
  logic [ElemBits-1:0] res_wd;
  logic                we_load, res_we;
  always_ff @(posedge clk) begin
    if (we_load) load_mem[load_position] <= elem;
    ld_rd <= load_mem[cnt[AddrBits-1:0]];
  end
  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    rs_rd <= res_mem[res_ra];
  end

  // memory port control
  always_comb begin
    we_load = (state == S_WRITE) && (item.cmd == CmdSample);
    res_we = 1'b0;
    res_wa = addr_a;
    res_wd = bf_a + rs_rd;
    res_ra = addr_a;
    if (state == S_IDLE) res_ra = drain_position;
    if (state == S_BFRB) res_ra = addr_b;
    if (state == S_COPY && cnt != '0) begin
      res_we = 1'b1; res_wa = AddrBits'(cnt - 1'b1); res_wd = ld_rd;
    end
    if (state == S_BFWA) begin
      res_we = 1'b1; res_wa = addr_a; res_wd = bf_a + rs_rd;
    end
    if (state == S_BFWB) begin
      res_we = 1'b1; res_wa = addr_b; res_wd = bf_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; load_position <= '0; drain_position <= '0;
      row_ready <= 1'b0; out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          item <= in_item;
          state <= S_MUL1;
        end
        S_MUL1: begin
          // emit pending element (read data rs_rd valid now)
          if (row_ready) begin
            out_valid <= 1'b1;
            out_item.out_value <= rs_rd;
            out_item.out_index <= drain_position;
            out_item.out_last  <= ((AddrBits+1)'(drain_position) + 1'b1) >= n;
            if (((AddrBits+1)'(drain_position) + 1'b1) >= n) begin
              row_ready <= 1'b0; drain_position <= '0;
            end else drain_position <= drain_position + 1'b1;
          end
          pw <= 18'((32'(item.sample) * 32'(item.weight) + 32'sd8192) >>> 14);
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod <= (use_weights ? 34'(pw) : 34'(item.sample))
                  * 34'($signed({1'b0, scale})) + 34'sd16384;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (item.cmd == CmdFlush) state <= S_IDLE;
          else if ((AddrBits+1)'(load_position) + 1'b1 >= n) begin
            load_position <= '0; drain_position <= '0;
            cnt <= '0; state <= S_COPY;
          end else begin
            load_position <= load_position + 1'b1; state <= S_IDLE;
          end
        end
        S_COPY: begin
          cnt <= cnt + 1'b1;
          if (cnt == n) begin
            stage <= '0; bf <= '0; state <= S_BFRA;
          end
        end
        S_BFRA: state <= S_BFRB;
        S_BFRB: begin
          bf_a <= rs_rd; state <= S_BFWA;
        end
        S_BFWA: begin
          bf_b <= bf_a - rs_rd; state <= S_BFWB;
        end
        S_BFWB: begin
          if ((AddrBits+1)'(bf) + 1'b1 >= (n >> 1)) begin
            bf <= '0;
            if (stage + 1'b1 >= lg) begin
              row_ready <= 1'b1; state <= S_IDLE;
            end else begin
              stage <= stage + 1'b1; state <= S_BFRA;
            end
          end else begin
            bf <= bf + 1'b1; state <= S_BFRA;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // rounded, wrapped element
  assign elem = ElemBits'(prod >>> 15);
endmodule

>>> sv/fwht_checker.sv
`timescale 1ns / 1ps
module fwht_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic out_valid,
  input fwht_pkg::out_item_t out_item
);
  import fwht_pkg::*;
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("no busy after start");
  a_out_in_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy) else $error("result outside item");
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid |=> !out_valid) else $error("two results for one beat");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(start && !busy, 2)) else $error("result without beat");
endmodule

bind fast_walsh_hadamard_transform fwht_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
